// ===== hdl/metp_pkg.sv =====
// ----------------------------------------------------------------------------
// metp_pkg: shared types and constants for the escape-time pixel evaluator
// Fixed-point formats, register indexes, reset values, payload structs and
// the coordinate saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package metp_pkg;

  // Q6.26 coordinates, 12-bit pixel indexes
  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 26;
  localparam int PIXEL_BITS    = 12;
  localparam int PROD_BITS     = 2 * COORD_BITS;
  localparam int WIDE_BITS     = PROD_BITS + 2;
  localparam int ITER_BITS     = 16;
  localparam int SIZE_BITS     = 13;
  localparam int STEP_BITS     = 31;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int COLOR_BITS    = 8;
  localparam int PAL_LEN       = 256 * 6;
  localparam int PAL_BITS      = $clog2(PAL_LEN);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_REAL    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_IMAG    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITERATIONS = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH    = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT   = CFG_IDX_BITS'(5);

  // reset values
  localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(67109);
  localparam coord_t               OFFSET_RESET = coord_t'(0);
  localparam logic [ITER_BITS-1:0] ITER_RESET   = ITER_BITS'(1536);
  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(1600);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(900);

  typedef struct packed {
    logic [STEP_BITS-1:0] step_size;
    coord_t               offset_real;
    coord_t               offset_imag;
    logic [ITER_BITS-1:0] max_iterations;
    logic [SIZE_BITS-1:0] frame_width;
    logic [SIZE_BITS-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic                  inside_res;
    logic [ITER_BITS-1:0]  escape_index;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
  } out_t;

  // sequencer result: escape step plus its position on the color ramp
  typedef struct packed {
    logic                 in_set;
    logic [ITER_BITS-1:0] escape_index;
    logic [PAL_BITS-1:0]  pal_idx;
  } res_t;

  localparam wide_t COORD_MAX_W = wide_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam wide_t COORD_MIN_W = -COORD_MAX_W - wide_t'(1);

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > COORD_MAX_W) begin
      r = COORD_MAX_W[COORD_BITS-1:0];
    end else if (v < COORD_MIN_W) begin
      r = COORD_MIN_W[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mandelbrot_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top: escape-time pixel evaluator with palette
// One pixel in, one colored result out. The pixel is mapped to
// c = step_size * (pixel - size/2) + offset in saturating Q6.26, points in
// the main cardioid are reported inside at once, and otherwise z = z*z - c_re
// + i*c_im is iterated from zero until |z|^2 > 4 or max_iterations steps have
// run. The escape step picks a color on a six-segment ramp; inside is black.
// Everything runs through one 32x32 signed multiplier, one product per cycle;
// an iteration needs three products (re^2, im^2, re*im). The default
// iteration limit is 1536. in_stall is high for the whole computation. The
// finished result sits in an output register, so the next pixel is accepted
// while it waits; the sequencer only holds if a second result is ready
// before the first has been taken. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data), to be written only while no pixel is in
// flight; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  metp_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output metp_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [metp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [metp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import metp_pkg::*;

  cfg_t   cfg_r;
  logic   busy;
  logic   start;
  logic   res_valid;
  logic   res_take;
  res_t   res;
  out_t   pix;
  coord_t mul_a;
  coord_t mul_b;
  prod_t  mul_prod;
  logic   out_valid_r, out_valid_nxt;
  out_t   out_data_r;

  // configuration registers; the user writes them only while idle, not enforced here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size      <= STEP_RESET;
      cfg_r.offset_real    <= OFFSET_RESET;
      cfg_r.offset_imag    <= OFFSET_RESET;
      cfg_r.max_iterations <= ITER_RESET;
      cfg_r.frame_width    <= WIDTH_RESET;
      cfg_r.frame_height   <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_SIZE:      cfg_r.step_size      <= cfg_data[STEP_BITS-1:0];
        CFG_OFFSET_REAL:    cfg_r.offset_real    <= $signed(cfg_data[COORD_BITS-1:0]);
        CFG_OFFSET_IMAG:    cfg_r.offset_imag    <= $signed(cfg_data[COORD_BITS-1:0]);
        CFG_MAX_ITERATIONS: cfg_r.max_iterations <= cfg_data[ITER_BITS-1:0];
        CFG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_data[SIZE_BITS-1:0];
        CFG_FRAME_HEIGHT:   cfg_r.frame_height   <= cfg_data[SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // input transfer only when the sequencer sits idle
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  metp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_prod  (mul_prod)
  );

  metp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  metp_palette u_palette (
    .res (res),
    .pix (pix)
  );

  // output register: load when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_data_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accepted pixel keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but sequencer not busy");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !res_take)
    else $error("result register loaded while stalled");

  // inside points come out black with index zero
  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.inside_res) |->
      (out_data_r.escape_index == '0 && out_data_r.blue == '0 &&
       out_data_r.green == '0 && out_data_r.red == '0))
    else $error("inside result with nonzero index or color");

  // an escape index stays below the iteration limit
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.inside_res) |->
      (out_data_r.escape_index < cfg_r.max_iterations))
    else $error("escape index at or above the iteration limit");

endmodule

`default_nettype wire

// ===== hdl/metp_mul.sv =====
// ----------------------------------------------------------------------------
// metp_mul: shared signed multiplier
// One signed COORD_BITS x COORD_BITS product per cycle, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metp_mul (
  input  logic            clk,
  input  metp_pkg::coord_t op_a,
  input  metp_pkg::coord_t op_b,
  output metp_pkg::prod_t  prod
);
  import metp_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_t'(op_a) * prod_t'(op_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== hdl/metp_palette.sv =====
// ----------------------------------------------------------------------------
// metp_palette: six-segment color ramp
// Maps the ramp position to blue, green and red; inside points are black.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metp_palette (
  input  metp_pkg::res_t res,
  output metp_pkg::out_t pix
);
  import metp_pkg::*;

  localparam int SEG_BITS = PAL_BITS - COLOR_BITS;

  localparam logic [SEG_BITS-1:0] SEG_GREEN_UP   = SEG_BITS'(1);
  localparam logic [SEG_BITS-1:0] SEG_BLUE_DOWN  = SEG_BITS'(2);
  localparam logic [SEG_BITS-1:0] SEG_RED_UP     = SEG_BITS'(3);
  localparam logic [SEG_BITS-1:0] SEG_GREEN_DOWN = SEG_BITS'(4);
  localparam logic [SEG_BITS-1:0] SEG_RED_DOWN   = SEG_BITS'(5);

  localparam logic [COLOR_BITS-1:0] FULL = '1;

  logic [SEG_BITS-1:0]   seg;
  logic [COLOR_BITS-1:0] ramp;
  logic [COLOR_BITS-1:0] b;
  logic [COLOR_BITS-1:0] g;
  logic [COLOR_BITS-1:0] r;

  assign seg  = res.pal_idx[PAL_BITS-1:COLOR_BITS];
  assign ramp = res.pal_idx[COLOR_BITS-1:0];

  always_comb begin
    b = '0;
    g = '0;
    r = '0;
    case (seg)
      SEG_GREEN_UP: begin
        g = ramp;
        b = FULL;
      end
      SEG_BLUE_DOWN: begin
        g = FULL;
        b = FULL - ramp;
      end
      SEG_RED_UP: begin
        r = ramp;
        g = FULL;
      end
      SEG_GREEN_DOWN: begin
        r = FULL;
        g = FULL - ramp;
      end
      SEG_RED_DOWN: begin
        r = FULL - ramp;
      end
      default: begin
        b = ramp;
      end
    endcase
    if (res.in_set) begin
      b = '0;
      g = '0;
      r = '0;
    end
  end

  assign pix.inside_res   = res.in_set;
  assign pix.escape_index = res.escape_index;
  assign pix.blue         = b;
  assign pix.green        = g;
  assign pix.red          = r;

endmodule

`default_nettype wire

// ===== hdl/metp_seq.sv =====
// ----------------------------------------------------------------------------
// metp_seq: pixel sequencer and datapath
// Maps the pixel to c, runs the cardioid test and the escape iteration,
// driving the shared multiplier one product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  metp_pkg::in_t    in_data,
  input  metp_pkg::cfg_t   cfg,
  output logic             busy,
  output logic             res_valid,
  output metp_pkg::res_t   res,
  input  logic             res_take,
  output metp_pkg::coord_t mul_a,
  output metp_pkg::coord_t mul_b,
  input  metp_pkg::prod_t  mul_prod
);
  import metp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_MAPI,
    S_CARD0,
    S_CARD1,
    S_CARD2,
    S_CARD3,
    S_CARD4,
    S_CARD5,
    S_INIT,
    S_MRR,
    S_MII,
    S_MRI,
    S_DONE
  } state_t;

  typedef logic signed [COORD_BITS+1:0] ext_t;
  typedef logic signed [PROD_BITS:0]    diff_t;

  localparam ext_t CARD_LIM = ext_t'(1) <<< (FRAC_BITS + 1);
  localparam ext_t QUARTER  = ext_t'(1) <<< (FRAC_BITS - 2);
  localparam logic [PROD_BITS:0] LIMIT4 = (PROD_BITS+1)'(4) << (2 * FRAC_BITS);

  state_t                state_r, state_nxt;
  logic [PIXEL_BITS-1:0] px_r, px_nxt;
  logic [PIXEL_BITS-1:0] py_r, py_nxt;
  coord_t                c_re_r, c_re_nxt;
  coord_t                c_im_r, c_im_nxt;
  coord_t                re_r, re_nxt;
  coord_t                im_r, im_nxt;
  coord_t                a_r, a_nxt;
  coord_t                q_r, q_nxt;
  coord_t                qa_r, qa_nxt;
  prod_t                 rr_r, rr_nxt;
  prod_t                 yy_r, yy_nxt;
  logic [ITER_BITS-1:0]  iter_r, iter_nxt;
  logic [PAL_BITS-1:0]   pal_r, pal_nxt;
  logic                  inside_r, inside_nxt;
  logic [ITER_BITS-1:0]  idx_r, idx_nxt;
  logic [PAL_BITS-1:0]   rpal_r, rpal_nxt;

  logic signed [SIZE_BITS-1:0] dx, dy;
  coord_t                step_c;
  coord_t                off_sel;
  wide_t                 map_w;
  ext_t                  card_a_w, card_y_w;
  logic                  card_out;
  logic [PROD_BITS:0]    q_sum;
  logic                  card_in;
  diff_t                 s_w;
  coord_t                nre, nim, re_init;
  logic [PROD_BITS:0]    mag;
  logic                  escaped;
  logic                  last_iter;
  logic                  no_iter;

  // pixel offsets from the frame center
  assign dx = $signed({1'b0, px_r}) - $signed({1'b0, cfg.frame_width[SIZE_BITS-1:1]});
  assign dy = $signed({1'b0, py_r}) - $signed({1'b0, cfg.frame_height[SIZE_BITS-1:1]});
  assign step_c  = $signed({1'b0, cfg.step_size});
  assign off_sel = (state_r == S_MAPY) ? cfg.offset_real : cfg.offset_imag;
  assign map_w   = wide_t'(mul_prod) + wide_t'(off_sel);

  // cardioid test runs on (-c_re, c_im)
  assign card_a_w = -ext_t'(c_re_r) - QUARTER;
  assign card_y_w = ext_t'(c_im_r);
  assign card_out = (card_a_w > CARD_LIM) || (card_a_w < -CARD_LIM) ||
                    (card_y_w > CARD_LIM) || (card_y_w < -CARD_LIM);
  assign q_sum    = {1'b0, mul_prod} + {1'b0, yy_r};
  assign card_in  = (wide_t'(mul_prod) <<< 2) <= wide_t'(yy_r);

  // z update: rr_r holds re^2, mul_prod holds im^2 (S_MRI) or re*im (S_MRR)
  assign s_w     = diff_t'(rr_r) - diff_t'(mul_prod);
  assign nre     = sat_coord(wide_t'(s_w >>> FRAC_BITS) - wide_t'(c_re_r));
  assign nim     = sat_coord(wide_t'(mul_prod >>> (FRAC_BITS - 1)) + wide_t'(c_im_r));
  assign re_init = sat_coord(-wide_t'(c_re_r));
  assign mag     = {1'b0, rr_r} + {1'b0, mul_prod};
  assign escaped = mag > LIMIT4;

  assign last_iter = iter_r == (cfg.max_iterations - ITER_BITS'(1));
  assign no_iter   = cfg.max_iterations == '0;

  always_comb begin
    state_nxt  = state_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    c_re_nxt   = c_re_r;
    c_im_nxt   = c_im_r;
    re_nxt     = re_r;
    im_nxt     = im_r;
    a_nxt      = a_r;
    q_nxt      = q_r;
    qa_nxt     = qa_r;
    rr_nxt     = rr_r;
    yy_nxt     = yy_r;
    iter_nxt   = iter_r;
    pal_nxt    = pal_r;
    inside_nxt = inside_r;
    idx_nxt    = idx_r;
    rpal_nxt   = rpal_r;
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          px_nxt    = in_data.pixel_x;
          py_nxt    = in_data.pixel_y;
          state_nxt = S_MAPX;
        end
      end
      S_MAPX: begin
        mul_a     = step_c;
        mul_b     = coord_t'(dx);
        state_nxt = S_MAPY;
      end
      S_MAPY: begin
        c_re_nxt  = sat_coord(map_w);
        mul_a     = step_c;
        mul_b     = coord_t'(dy);
        state_nxt = S_MAPI;
      end
      S_MAPI: begin
        c_im_nxt  = sat_coord(map_w);
        state_nxt = S_CARD0;
      end
      S_CARD0: begin
        a_nxt = card_a_w[COORD_BITS-1:0];
        if (!card_out) begin
          mul_a     = c_im_r;
          mul_b     = c_im_r;
          state_nxt = S_CARD1;
        end else if (no_iter) begin
          inside_nxt = 1'b1;
          idx_nxt    = '0;
          rpal_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_CARD1: begin
        yy_nxt    = mul_prod;
        mul_a     = a_r;
        mul_b     = a_r;
        state_nxt = S_CARD2;
      end
      S_CARD2: begin
        q_nxt     = coord_t'(q_sum >> FRAC_BITS);
        state_nxt = S_CARD3;
      end
      S_CARD3: begin
        qa_nxt    = q_r + a_r;
        state_nxt = S_CARD4;
      end
      S_CARD4: begin
        mul_a     = q_r;
        mul_b     = qa_r;
        state_nxt = S_CARD5;
      end
      S_CARD5: begin
        if (card_in || no_iter) begin
          inside_nxt = 1'b1;
          idx_nxt    = '0;
          rpal_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        // multiplier fed zero so the first im update sees re*im = 0
        re_nxt    = re_init;
        iter_nxt  = '0;
        pal_nxt   = '0;
        state_nxt = S_MRR;
      end
      S_MRR: begin
        im_nxt    = nim;
        mul_a     = re_r;
        mul_b     = re_r;
        state_nxt = S_MII;
      end
      S_MII: begin
        rr_nxt    = mul_prod;
        mul_a     = im_r;
        mul_b     = im_r;
        state_nxt = S_MRI;
      end
      S_MRI: begin
        mul_a  = re_r;
        mul_b  = im_r;
        re_nxt = nre;
        if (escaped) begin
          inside_nxt = 1'b0;
          idx_nxt    = iter_r;
          rpal_nxt   = pal_r;
          state_nxt  = S_DONE;
        end else if (last_iter) begin
          inside_nxt = 1'b1;
          idx_nxt    = '0;
          rpal_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          iter_nxt  = iter_r + ITER_BITS'(1);
          pal_nxt   = (pal_r == PAL_BITS'(PAL_LEN - 1)) ? '0 : pal_r + PAL_BITS'(1);
          state_nxt = S_MRR;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    c_re_r   <= c_re_nxt;
    c_im_r   <= c_im_nxt;
    re_r     <= re_nxt;
    im_r     <= im_nxt;
    a_r      <= a_nxt;
    q_r      <= q_nxt;
    qa_r     <= qa_nxt;
    rr_r     <= rr_nxt;
    yy_r     <= yy_nxt;
    iter_r   <= iter_nxt;
    pal_r    <= pal_nxt;
    inside_r <= inside_nxt;
    idx_r    <= idx_nxt;
    rpal_r   <= rpal_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign res_valid        = state_r == S_DONE;
  assign res.in_set       = inside_r;
  assign res.escape_index = idx_r;
  assign res.pal_idx      = rpal_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mandelbrot_escape_time_pixel_top
// Pixels go in through a valid/stall driver and colored results come back
// through a monitor that checks every field against a fixed-point Mandelbrot
// predictor kept in step with the configuration writes. Directed corners
// come first, then a sweep toward the cusp for long escape counts and wraps
// of the color ramp, then randomized frames with random idle and stall bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import metp_pkg::*;

  // Watchdog on the whole run.
  localparam longint RUN_LIMIT_NS = 200_000_000;

  // Register indexes the block has no use for; writes there must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(6);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(7);

  // Q6.26 bounds and constants at 64-bit width
  localparam longint COORD_TOP     = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_BOTTOM  = -COORD_TOP - 1;
  localparam longint QUARTER       = 64'sd1 <<< (FRAC_BITS - 2);
  localparam longint CARDIOID_SPAN = 64'sd1 <<< (FRAC_BITS + 1);
  localparam longint unsigned ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);
  localparam logic [COLOR_BITS-1:0] COLOR_FULL = 8'hff;

  // Segments of the color ramp, 256 steps each
  typedef enum int {
    SEG_BLACK_BLUE,
    SEG_BLUE_CYAN,
    SEG_CYAN_GREEN,
    SEG_GREEN_YELLOW,
    SEG_YELLOW_RED,
    SEG_RED_BLACK
  } ramp_seg_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Shadow of the register file, updated as each write goes out
  cfg_t frame_cfg;

  in_t  pending_pixels[$];    // pixels waiting for the driver
  out_t predicted_pixels[$];  // expected results, oldest first

  int fail_count = 0;
  int idle_pct   = 0;         // chance per cycle that a sender gap starts
  int stall_pct  = 0;         // chance per cycle that a receiver stall starts
  bit calm       = 1'b0;      // no gaps or stalls at all (final stretch)
  int gap_left   = 0;
  int stall_left = 0;

  mandelbrot_escape_time_pixel_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic longint clamp_q26(longint v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_BOTTOM) return COORD_BOTTOM;
    return v;
  endfunction

  // c = step * (pixel - floor(size/2)) + offset, saturated
  function automatic longint map_axis(logic [PIXEL_BITS-1:0] pix,
                                      logic [SIZE_BITS-1:0] size,
                                      logic [STEP_BITS-1:0] step,
                                      coord_t off);
    longint px, half, st, o;
    px   = pix;
    half = size >> 1;
    st   = step;
    o    = off;
    return clamp_q26(st * (px - half) + o);
  endfunction

  // Exact algebraic main-cardioid test on (x, y); >>> on signed is a floor.
  function automatic bit in_main_cardioid(longint x, longint y);
    longint a, q, yy;
    a = x - QUARTER;
    if (a > CARDIOID_SPAN || a < -CARDIOID_SPAN ||
        y > CARDIOID_SPAN || y < -CARDIOID_SPAN) begin
      return 1'b0;
    end
    yy = y * y;
    q  = (a * a + yy) >>> FRAC_BITS;
    return (4 * q * (q + a) <= yy);
  endfunction

  function automatic out_t compute_pixel(in_t pix);
    longint c_re, c_im, re, im, nre, nim, i, iters;
    longint unsigned sq_re, sq_im;
    bit escaped;
    int ramp;
    logic [COLOR_BITS-1:0] shade;
    out_t r;
    c_re = map_axis(pix.pixel_x, frame_cfg.frame_width, frame_cfg.step_size,
                    frame_cfg.offset_real);
    c_im = map_axis(pix.pixel_y, frame_cfg.frame_height, frame_cfg.step_size,
                    frame_cfg.offset_imag);
    iters = frame_cfg.max_iterations;
    escaped = 1'b0;
    r = '0;
    r.inside_res = 1'b1;
    // the point under test is (-c_re, c_im)
    if (!in_main_cardioid(-c_re, c_im)) begin
      re = 0;
      im = 0;
      for (i = 0; i < iters && !escaped; i++) begin
        nre = clamp_q26(((re * re - im * im) >>> FRAC_BITS) - c_re);
        nim = clamp_q26(((re * im) >>> (FRAC_BITS - 1)) + c_im);
        re = nre;
        im = nim;
        // both squares are at most 2^62, so the unsigned sum is exact
        sq_re = re * re;
        sq_im = im * im;
        if (sq_re + sq_im > ESCAPE_LIMIT) begin
          escaped = 1'b1;
          r.escape_index = i[ITER_BITS-1:0];
        end
      end
    end
    if (escaped) begin
      r.inside_res = 1'b0;
      ramp  = r.escape_index % PAL_LEN;
      shade = ramp[7:0];
      case (ramp_seg_e'(ramp / 256))
        SEG_BLUE_CYAN: begin
          r.green = shade;
          r.blue  = COLOR_FULL;
        end
        SEG_CYAN_GREEN: begin
          r.green = COLOR_FULL;
          r.blue  = COLOR_FULL - shade;
        end
        SEG_GREEN_YELLOW: begin
          r.red   = shade;
          r.green = COLOR_FULL;
        end
        SEG_YELLOW_RED: begin
          r.red   = COLOR_FULL;
          r.green = COLOR_FULL - shade;
        end
        SEG_RED_BLACK: begin
          r.red = COLOR_FULL - shade;
        end
        default: begin
          r.blue = shade;
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one pixel per transfer, held steady while stalled. Expectations
  // are computed at the transfer edge from the register shadow.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_pixels.push_back(compute_pixel(in_data));
      end
      // a new decision only when nothing is held
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(99) < idle_pct) begin
          gap_left = $urandom_range(9);  // starts a gap burst
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each result transfer, stalls in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_pixels.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = predicted_pixels.pop_front();
          if (out_data.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d",
                   want.inside_res, out_data.inside_res);
            fail_count++;
          end
          if (out_data.escape_index !== want.escape_index) begin
            $error("escape_index: expected %0d, got %0d",
                   want.escape_index, out_data.escape_index);
            fail_count++;
          end
          if (out_data.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
            fail_count++;
          end
          if (out_data.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_data.green);
            fail_count++;
          end
          if (out_data.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_data.red);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Caller sits on a rising edge; returns on the edge that takes the write.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx,
                           logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_STEP_SIZE:      frame_cfg.step_size      = data[STEP_BITS-1:0];
      CFG_OFFSET_REAL:    frame_cfg.offset_real    = data;
      CFG_OFFSET_IMAG:    frame_cfg.offset_imag    = data;
      CFG_MAX_ITERATIONS: frame_cfg.max_iterations = data[ITER_BITS-1:0];
      CFG_FRAME_WIDTH:    frame_cfg.frame_width    = data[SIZE_BITS-1:0];
      CFG_FRAME_HEIGHT:   frame_cfg.frame_height   = data[SIZE_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_frame(logic [31:0] step, logic [31:0] off_re,
                            logic [31:0] off_im, logic [31:0] iters,
                            logic [31:0] width, logic [31:0] height);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_OFFSET_REAL, off_re);
    write_reg(CFG_OFFSET_IMAG, off_im);
    write_reg(CFG_MAX_ITERATIONS, iters);
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(int x, int y);
    in_t p;
    p.pixel_x = x[PIXEL_BITS-1:0];
    p.pixel_y = y[PIXEL_BITS-1:0];
    pending_pixels.push_back(p);
  endtask

  // Sender holds off until every result is back, plus a short quiet spell.
  // Checked at the falling edge, where the sender and receiver have settled.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || predicted_pixels.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One randomized frame: pick a register set, then mostly on-frame pixels
  // with some anywhere in the 12-bit range.
  task automatic random_batch(int count);
    logic [31:0] step, off_re, off_im, iters, width, height;
    int x_top, y_top, k;
    case ($urandom_range(7))
      0:       width = 1;
      1:       width = 4096;
      2:       width = $urandom();          // out-of-range sizes, masked
      default: width = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(7))
      0:       height = 1;
      1:       height = 4096;
      2:       height = $urandom();
      default: height = $urandom_range(1, 4096);
    endcase
    x_top = (width[SIZE_BITS-1:0] == 0) ? 1 : width[SIZE_BITS-1:0];
    y_top = (height[SIZE_BITS-1:0] == 0) ? 1 : height[SIZE_BITS-1:0];
    if (x_top > 4096) x_top = 4096;
    if (y_top > 4096) y_top = 4096;
    case ($urandom_range(9))
      0:       step = 0;
      1:       step = $urandom() >> 1;
      2:       step = 32'h7fff_ffff;
      3:       step = $urandom_range(1, 2000);   // deep zoom
      default: step = ($urandom_range(2, 6) << FRAC_BITS) / x_top;
    endcase
    off_re = ($urandom_range(3) == 0) ? $urandom()
           : $urandom_range(0, 5 << FRAC_BITS) - (5 << (FRAC_BITS - 1));
    off_im = ($urandom_range(3) == 0) ? $urandom()
           : $urandom_range(0, 3 << FRAC_BITS) - (3 << (FRAC_BITS - 1));
    case ($urandom_range(19))
      0:          iters = 0;
      1, 2, 3:    iters = $urandom_range(80, 400);
      default:    iters = $urandom_range(1, 80);
    endcase
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
    end
    load_frame(step, off_re, off_im, iters, width, height);
    idle_pct  = 17 * $urandom_range(2);
    stall_pct = 17 * $urandom_range(2);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(6) == 0) begin
        push_pixel($urandom_range(4095), $urandom_range(4095));
      end else begin
        push_pixel($urandom_range(x_top - 1), $urandom_range(y_top - 1));
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    frame_cfg.step_size      = STEP_RESET;
    frame_cfg.offset_real    = OFFSET_RESET;
    frame_cfg.offset_imag    = OFFSET_RESET;
    frame_cfg.max_iterations = ITER_RESET;
    frame_cfg.frame_width    = WIDTH_RESET;
    frame_cfg.frame_height   = HEIGHT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: 1600x900 frame at ~0.001 per pixel, limit 1536.
    idle_pct  = 20;
    stall_pct = 20;
    push_pixel(0, 0);
    push_pixel(4095, 4095);     // escapes on the first step
    push_pixel(0, 4095);
    push_pixel(4095, 0);
    push_pixel(800, 450);       // c = 0, inside the cardioid
    push_pixel(1800, 450);      // period-2 bulb, runs the whole limit
    push_pixel(550, 450);       // just past the cusp
    push_pixel(549, 450);       // near the cusp, escapes after ~100 steps
    push_pixel(1550, 450);      // cardioid/bulb junction
    push_pixel(800, 1400);
    wait_idle();

    // Zero iteration limit: everything off the cardioid is still inside.
    load_frame(STEP_RESET, OFFSET_RESET, OFFSET_RESET, 0, WIDTH_RESET,
               HEIGHT_RESET);
    push_pixel(0, 0);
    push_pixel(1800, 450);
    push_pixel(4095, 4095);
    wait_idle();

    // Saturated coordinates at full iteration limit. Every point has a
    // component pinned near +-32, so it leaves on step 0; c_re at the
    // negative rail drives re past the top and clamps it.
    load_frame(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 65535, 1, 1);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(1, 1);
    wait_idle();
    load_frame(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 65535, 1, 1);
    push_pixel(0, 0);
    push_pixel(4095, 0);
    wait_idle();

    // Zero step, zero height: every pixel lands on the cusp, which the
    // cardioid test takes as inside. Unused indexes get junk first.
    write_reg(CFG_SPARE_A, $urandom());
    write_reg(CFG_SPARE_B, $urandom());
    load_frame(0, 32'hff00_0000, 0, 65535, 4096, 0);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(2048, 0);
    wait_idle();

    // Real axis just right of the cusp: escape counts run into the
    // thousands, walking the whole color ramp and wrapping it.
    load_frame(5, 32'hfeff_ff9c, 0, 3000, 4096, 4096);
    idle_pct  = 10;
    stall_pct = 30;
    for (k = 0; k < 30; k++) begin
      push_pixel($urandom_range(1) ? $urandom_range(1990, 2047)
                                   : $urandom_range(0, 2047),
                 $urandom_range(2047, 2049));
    end
    wait_idle();

    // Randomized frames; the last one runs without gaps or stalls.
    for (k = 0; k < 10; k++) begin
      if (k == 9) calm = 1'b1;
      random_batch(33);
    end

    // catch any stray result transfer
    repeat (50) @(posedge clk);
    if (predicted_pixels.size() != 0) begin
      $error("%0d expected results never arrived", predicted_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[mandelbrot_escape_time_pixel_top] OK");
    end else begin
      $display("[mandelbrot_escape_time_pixel_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[mandelbrot_escape_time_pixel_top] ERROR");
    $finish;
  end

endmodule
